### src/jsm_pkg.sv
`timescale 1ns / 1ps
package jsm_pkg;

	// scan modes of the lexer
	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_SQUOTE = 3'd1,
		MODE_DQUOTE = 3'd2,
		MODE_REGEX  = 3'd3,
		MODE_RCLASS = 3'd4,
		MODE_LINE   = 3'd5,
		MODE_BLOCK  = 3'd6,
		MODE_FLAGS  = 3'd7
	} mode_t;

	localparam int unsigned MaxWords = 5;
	localparam int unsigned CntW = 3;

	// character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_QUEST  = 8'h3F;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_TILDE  = 8'h7E;

	// lexer state
	typedef struct packed {
		mode_t       mode;
		logic        esc;
		logic        sp;
		logic [7:0]  prev;
		logic [7:0]  lastem;
		logic        slash;
		logic        star;
	} lex_state_t;

	// words produced by one source byte
	typedef struct packed {
		logic [MaxWords-1:0][7:0] bytes;
		logic [CntW-1:0]          n;
		logic                     bare;
		logic                     eot;
	} bundle_t;

	// working set while one byte is scanned
	typedef struct packed {
		lex_state_t               st;
		logic [MaxWords-1:0][7:0] bytes;
		logic [CntW-1:0]          n;
	} work_t;

	localparam lex_state_t LexReset = '{
		mode: MODE_NORMAL, esc: 1'b0, sp: 1'b0, prev: CH_NUL,
		lastem: CH_NUL, slash: 1'b0, star: 1'b0
	};

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_ident(logic [7:0] c);
		return is_alpha(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER || c == CH_DOLLAR;
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic opens_regex(logic [7:0] c);
		logic r;
		case (c)
			CH_NUL, CH_LPAREN, CH_LBRACK, CH_LBRACE, CH_COLON, CH_SEMI, CH_COMMA,
			CH_EQ, CH_BANG, CH_QUEST, CH_AMP, CH_PIPE, CH_PLUS, CH_MINUS,
			CH_STAR, CH_PCT, CH_CARET, CH_TILDE, CH_LT, CH_GT: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// append one byte, up to the word limit
	function automatic work_t put(work_t w, logic [7:0] b);
		work_t r;
		r = w;
		if (w.n < CntW'(MaxWords)) begin
			r.bytes[w.n] = b;
			r.n = w.n + CntW'(1);
			r.st.lastem = b;
		end
		return r;
	endfunction

	// emit the pending space only where the tokens would otherwise merge
	function automatic work_t space_flush(work_t w, logic [7:0] nx);
		work_t r;
		logic [7:0] p;
		r = w;
		p = w.st.lastem;
		if (w.st.sp) begin
			if ((is_ident(p) && is_ident(nx)) || (p == CH_PLUS && nx == CH_PLUS) ||
			    (p == CH_MINUS && nx == CH_MINUS) || (p == CH_SLASH && nx == CH_SLASH) ||
			    (p == CH_SLASH && nx == CH_STAR)) begin
				r = put(r, CH_SPACE);
			end
			r.st.sp = 1'b0;
		end
		return r;
	endfunction

	function automatic work_t normal_char(work_t w, logic [7:0] c);
		work_t r;
		r = space_flush(w, c);
		if (c == CH_SQUOTE) begin
			r.st.mode = MODE_SQUOTE;
			r.st.esc = 1'b0;
			r = put(r, c);
		end else if (c == CH_DQUOTE) begin
			r.st.mode = MODE_DQUOTE;
			r.st.esc = 1'b0;
			r = put(r, c);
		end else if (c == CH_SLASH && opens_regex(r.st.prev)) begin
			r.st.mode = MODE_REGEX;
			r.st.esc = 1'b0;
			r = put(r, c);
		end else begin
			r = put(r, c);
			r.st.prev = c;
		end
		return r;
	endfunction

	// one byte in the current scan mode
	function automatic work_t process_byte(work_t w, logic [7:0] c);
		work_t r;
		logic  done;
		r = w;
		done = 1'b1;
		case (w.st.mode)
			MODE_LINE: begin
				if (c == CH_LF || c == CH_CR) begin
					r.st.mode = MODE_NORMAL;
					r.st.sp = 1'b1;
				end
			end
			MODE_BLOCK: begin
				if (w.st.star && c == CH_SLASH) begin
					r.st.mode = MODE_NORMAL;
					r.st.sp = 1'b1;
					r.st.star = 1'b0;
				end else begin
					r.st.star = (c == CH_STAR);
				end
			end
			MODE_SQUOTE, MODE_DQUOTE: begin
				r = put(r, c);
				if (w.st.esc) begin
					r.st.esc = 1'b0;
				end else if (c == CH_BSLASH) begin
					r.st.esc = 1'b1;
				end else if ((w.st.mode == MODE_SQUOTE && c == CH_SQUOTE) ||
				             (w.st.mode == MODE_DQUOTE && c == CH_DQUOTE)) begin
					r.st.mode = MODE_NORMAL;
					r.st.prev = c;
				end
			end
			MODE_REGEX, MODE_RCLASS: begin
				r = put(r, c);
				if (w.st.esc) begin
					r.st.esc = 1'b0;
				end else if (c == CH_BSLASH) begin
					r.st.esc = 1'b1;
				end else if (w.st.mode == MODE_REGEX && c == CH_LBRACK) begin
					r.st.mode = MODE_RCLASS;
				end else if (w.st.mode == MODE_RCLASS && c == CH_RBRACK) begin
					r.st.mode = MODE_REGEX;
				end else if (w.st.mode == MODE_REGEX && c == CH_SLASH) begin
					r.st.mode = MODE_FLAGS;
					r.st.prev = CH_SLASH;
				end
			end
			MODE_FLAGS: begin
				if (is_alpha(c)) begin
					r = put(r, c);
				end else begin
					r.st.mode = MODE_NORMAL;
					done = 1'b0;
				end
			end
			default: begin
				r.st.mode = MODE_NORMAL;
				done = 1'b0;
			end
		endcase
		if (!done) begin
			if (is_space(c)) begin
				r.st.sp = 1'b1;
			end else if (c == CH_SLASH) begin
				r.st.slash = 1'b1;
			end else begin
				r = normal_char(r, c);
			end
		end
		return r;
	endfunction

endpackage

### src/jsm_if.sv
`timescale 1ns / 1ps
// source text channel
interface jsm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// minified text channel
interface jsm_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       end_of_text;

	modport source (output valid, output out_byte, output has_byte, output end_of_text,
		input ready);
	modport sink (input valid, input out_byte, input has_byte, input end_of_text,
		output ready);
endinterface

### src/js_text_minifier_core.sv
`timescale 1ns / 1ps
// JavaScript minifier: takes source text one byte per word and returns it with line and block
// comments removed and whitespace collapsed, keeping strings and regex literals intact. A byte is
// taken every cycle as long as the two-entry bundle queue has room; one byte yields up to three
// output words, which leave through the output register at one word per cycle while the receiver is
// ready; once the queue is full, the input waits until the queue head has been sent. The words
// of a byte pass through a queue entry, then the output register. The final word of a text carries
// end_of_text; if the last byte makes no output, a bare word with has_byte low is sent instead.
// After the last byte the lexer is back in its reset state for the next text.
module js_text_minifier_core (
	input  logic      clk,
	input  logic      arst_n,
	jsm_in_if.sink    source_text,
	jsm_out_if.source minified
);

	logic             push;
	logic             push_ready;
	jsm_pkg::bundle_t push_data;
	logic             pop;
	logic             head_valid;
	jsm_pkg::bundle_t head_data;

	jsm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.source_text (source_text),
		.q_ready     (push_ready),
		.q_push      (push),
		.q_data      (push_data)
	);

	jsm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	jsm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.minified   (minified)
	);

endmodule

### src/jsm_front.sv
`timescale 1ns / 1ps
// front end: takes one source byte per cycle while the queue has room, runs the lexer, queues its words
module jsm_front (
	input  logic             clk,
	input  logic             arst_n,
	jsm_in_if.sink           source_text,
	input  logic             q_ready,
	output logic             q_push,
	output jsm_pkg::bundle_t q_data
);

	jsm_pkg::lex_state_t st_q;
	jsm_pkg::lex_state_t st_next;
	jsm_pkg::work_t      w;
	logic                take;

	assign source_text.ready = q_ready;
	assign take = source_text.valid && q_ready;

	// lexer step for the byte on the input
	always_comb begin
		w.st = st_q;
		w.bytes = '0;
		w.n = '0;
		if (st_q.slash && st_q.mode == jsm_pkg::MODE_NORMAL) begin
			w.st.slash = 1'b0;
			if (source_text.in_byte == jsm_pkg::CH_SLASH) begin
				w.st.mode = jsm_pkg::MODE_LINE;
			end else if (source_text.in_byte == jsm_pkg::CH_STAR) begin
				w.st.mode = jsm_pkg::MODE_BLOCK;
				w.st.star = 1'b0;
			end else begin
				w = jsm_pkg::normal_char(w, jsm_pkg::CH_SLASH);
				w = jsm_pkg::process_byte(w, source_text.in_byte);
			end
		end else begin
			w.st.slash = 1'b0;
			w = jsm_pkg::process_byte(w, source_text.in_byte);
		end
		// end of text releases a held slash
		if (source_text.in_last && w.st.slash) begin
			w.st.slash = 1'b0;
			w = jsm_pkg::normal_char(w, jsm_pkg::CH_SLASH);
		end
	end

	// words for the queue
	always_comb begin
		q_data.bytes = w.bytes;
		q_data.eot = source_text.in_last;
		q_data.bare = source_text.in_last && (w.n == '0);
		q_data.n = q_data.bare ? jsm_pkg::CntW'(1) : w.n;
		q_push = take && (source_text.in_last || (w.n != '0));
		st_next = source_text.in_last ? jsm_pkg::LexReset : w.st;
	end

	// lexer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= jsm_pkg::LexReset;
		end else if (take) begin
			st_q <= st_next;
		end
	end

endmodule

### src/jsm_queue.sv
`timescale 1ns / 1ps
// two-entry queue of word bundles between front and back
module jsm_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jsm_pkg::bundle_t push_data,
	output logic             push_ready,
	input  logic             pop,
	output logic             head_valid,
	output jsm_pkg::bundle_t head_data
);

	jsm_pkg::bundle_t ent_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign head_valid = (fill_q != 2'd0);
	assign head_data = ent_q[rd_ptr_q];
	assign do_push = push && push_ready;
	assign do_pop = pop && head_valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

### src/jsm_back.sv
`timescale 1ns / 1ps
// back end: sends each queued bundle's words one per cycle, while the receiver is ready, through an output register
module jsm_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  jsm_pkg::bundle_t head_data,
	output logic             pop,
	jsm_out_if.source        minified
);

	logic [jsm_pkg::CntW-1:0] idx_q;
	logic                     valid_q;
	logic [7:0]               byte_q;
	logic                     has_q;
	logic                     eot_q;
	logic                     load;
	logic                     at_end;

	assign load = head_valid && (!valid_q || minified.ready);
	assign at_end = (idx_q == head_data.n - jsm_pkg::CntW'(1));
	assign pop = load && at_end;

	assign minified.valid = valid_q;
	assign minified.out_byte = byte_q;
	assign minified.has_byte = has_q;
	assign minified.end_of_text = eot_q;

	// word index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= at_end ? '0 : idx_q + jsm_pkg::CntW'(1);
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (minified.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head_data.bare ? jsm_pkg::CH_NUL : head_data.bytes[idx_q];
			has_q <= !head_data.bare;
			eot_q <= head_data.eot && at_end;
		end
	end

endmodule

### tb/sv/js_text_minifier_core_tb.sv
`timescale 1ns / 1ps
module js_text_minifier_core_tb;

	// one word on the minified channel
	typedef struct packed {
		logic [7:0] b;
		logic       has;
		logic       eot;
	} mini_word_t;

	// one directed source word, with its single result where it is obvious
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       typed;
		mini_word_t want;
	} row_t;

	localparam int NumRows = 28;
	localparam int PhaseItems = 100;
	localparam int HoldCycles = 150;
	localparam int DrainCycles = 16;
	localparam int CycleLimit = 300000;
	localparam int ReportLimit = 10;

	// texts that end at once, then x<tab>y/**/+ +/[/]\//g''//<lf>"
	localparam row_t Rows [NumRows] = '{
		'{8'hFF, 1'b1, 1'b1, {8'hFF, 1'b1, 1'b1}},
		'{jsm_pkg::CH_NUL, 1'b1, 1'b1, {jsm_pkg::CH_NUL, 1'b1, 1'b1}},
		'{jsm_pkg::CH_SPACE, 1'b1, 1'b1, {jsm_pkg::CH_NUL, 1'b0, 1'b1}},
		'{jsm_pkg::CH_SLASH, 1'b1, 1'b1, {jsm_pkg::CH_SLASH, 1'b1, 1'b1}},
		'{8'h78, 1'b0, 1'b0, '0},
		'{jsm_pkg::CH_TAB, 1'b0, 1'b0, '0},
		'{8'h79, 1'b0, 1'b0, '0},
		'{jsm_pkg::CH_SLASH, 1'b0, 1'b0, '0},
		'{jsm_pkg::CH_STAR, 1'b0, 1'b0, '0},
		'{jsm_pkg::CH_STAR, 1'b0, 1'b0, '0},
		'{jsm_pkg::CH_SLASH, 1'b0, 1'b0, '0},
		'{jsm_pkg::CH_PLUS, 1'b0, 1'b0, '0},
		'{jsm_pkg::CH_SPACE, 1'b0, 1'b0, '0},
		'{jsm_pkg::CH_PLUS, 1'b0, 1'b0, '0},
		'{jsm_pkg::CH_SLASH, 1'b0, 1'b0, '0},
		'{jsm_pkg::CH_LBRACK, 1'b0, 1'b0, '0},
		'{jsm_pkg::CH_SLASH, 1'b0, 1'b0, '0},
		'{jsm_pkg::CH_RBRACK, 1'b0, 1'b0, '0},
		'{jsm_pkg::CH_BSLASH, 1'b0, 1'b0, '0},
		'{jsm_pkg::CH_SLASH, 1'b0, 1'b0, '0},
		'{jsm_pkg::CH_SLASH, 1'b0, 1'b0, '0},
		'{8'h67, 1'b0, 1'b0, '0},
		'{jsm_pkg::CH_SQUOTE, 1'b0, 1'b0, '0},
		'{jsm_pkg::CH_SQUOTE, 1'b0, 1'b0, '0},
		'{jsm_pkg::CH_SLASH, 1'b0, 1'b0, '0},
		'{jsm_pkg::CH_SLASH, 1'b0, 1'b0, '0},
		'{jsm_pkg::CH_LF, 1'b0, 1'b0, '0},
		'{jsm_pkg::CH_DQUOTE, 1'b1, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic       src_valid = 1'b0;
	logic [7:0] src_byte = '0;
	logic       src_last = 1'b0;
	logic       sink_ready = 1'b0;
	logic       hold_off = 1'b0;

	int idle_pct = 0;
	int stall_pct = 0;
	int fault_count = 0;
	int unsigned cycle_count = 0;
	event squeeze_go;

	// lexer mirror
	jsm_pkg::mode_t lx_mode = jsm_pkg::MODE_NORMAL;
	logic           lx_escape = 1'b0;
	logic           lx_gap = 1'b0;
	logic [7:0]     lx_prev = jsm_pkg::CH_NUL;
	logic [7:0]     lx_tail = jsm_pkg::CH_NUL;
	logic           lx_slash = 1'b0;
	logic           lx_star = 1'b0;

	mini_word_t step_words [$];
	mini_word_t due_words [$];
	logic [7:0] text_buf [$];

	jsm_in_if  text_ch ();
	jsm_out_if mini_ch ();

	assign text_ch.valid = src_valid;
	assign text_ch.in_byte = src_byte;
	assign text_ch.in_last = src_last;
	assign mini_ch.ready = sink_ready;

	js_text_minifier_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.source_text(text_ch),
		.minified(mini_ch)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// queue appends
	function automatic void add_char(logic [7:0] c);
		text_buf.insert(text_buf.size(), c);
	endfunction

	function automatic void add_step(mini_word_t w);
		step_words.insert(step_words.size(), w);
	endfunction

	function automatic void add_due(mini_word_t w);
		due_words.insert(due_words.size(), w);
	endfunction

	// character classes
	function automatic bit letter(logic [7:0] c);
		return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

	function automatic bit word_char(logic [7:0] c);
		return letter(c) || (c inside {[8'h30:8'h39], jsm_pkg::CH_UNDER, jsm_pkg::CH_DOLLAR});
	endfunction

	function automatic bit blank(logic [7:0] c);
		return c inside {jsm_pkg::CH_SPACE, [jsm_pkg::CH_TAB:jsm_pkg::CH_CR]};
	endfunction

	// a slash after one of these opens a regex rather than dividing
	function automatic bit starts_regex(logic [7:0] c);
		return c inside {jsm_pkg::CH_NUL, jsm_pkg::CH_LPAREN, jsm_pkg::CH_LBRACK,
			jsm_pkg::CH_LBRACE, jsm_pkg::CH_COLON, jsm_pkg::CH_SEMI, jsm_pkg::CH_COMMA,
			jsm_pkg::CH_EQ, jsm_pkg::CH_BANG, jsm_pkg::CH_QUEST, jsm_pkg::CH_AMP,
			jsm_pkg::CH_PIPE, jsm_pkg::CH_PLUS, jsm_pkg::CH_MINUS, jsm_pkg::CH_STAR,
			jsm_pkg::CH_PCT, jsm_pkg::CH_CARET, jsm_pkg::CH_TILDE, jsm_pkg::CH_LT,
			jsm_pkg::CH_GT};
	endfunction

	// append one output word, capped at the bundle size
	function automatic void emit(logic [7:0] c);
		if (step_words.size() < jsm_pkg::MaxWords) begin
			add_step(mini_word_t'{c, 1'b1, 1'b0});
			lx_tail = c;
		end
	endfunction

	// skipped whitespace only survives where tokens would merge
	function automatic void gap_flush(logic [7:0] nx);
		if (lx_gap) begin
			if ((word_char(lx_tail) && word_char(nx)) ||
			    (lx_tail == nx &&
			     (nx inside {jsm_pkg::CH_PLUS, jsm_pkg::CH_MINUS, jsm_pkg::CH_SLASH})) ||
			    (lx_tail == jsm_pkg::CH_SLASH && nx == jsm_pkg::CH_STAR)) begin
				emit(jsm_pkg::CH_SPACE);
			end
			lx_gap = 1'b0;
		end
	endfunction

	// significant byte of normal text
	function automatic void plain(logic [7:0] c);
		gap_flush(c);
		if (c == jsm_pkg::CH_SQUOTE || c == jsm_pkg::CH_DQUOTE) begin
			lx_mode = (c == jsm_pkg::CH_SQUOTE) ? jsm_pkg::MODE_SQUOTE : jsm_pkg::MODE_DQUOTE;
			lx_escape = 1'b0;
			emit(c);
		end else if (c == jsm_pkg::CH_SLASH && starts_regex(lx_prev)) begin
			lx_mode = jsm_pkg::MODE_REGEX;
			lx_escape = 1'b0;
			emit(c);
		end else begin
			emit(c);
			lx_prev = c;
		end
	endfunction

	// one byte in whatever mode the lexer is in
	function automatic void scan(logic [7:0] c);
		bit fall;
		fall = 1'b0;
		case (lx_mode)
			jsm_pkg::MODE_LINE: begin
				if (c == jsm_pkg::CH_LF || c == jsm_pkg::CH_CR) begin
					lx_mode = jsm_pkg::MODE_NORMAL;
					lx_gap = 1'b1;
				end
			end
			jsm_pkg::MODE_BLOCK: begin
				if (lx_star && c == jsm_pkg::CH_SLASH) begin
					lx_mode = jsm_pkg::MODE_NORMAL;
					lx_gap = 1'b1;
					lx_star = 1'b0;
				end else begin
					lx_star = (c == jsm_pkg::CH_STAR);
				end
			end
			jsm_pkg::MODE_SQUOTE, jsm_pkg::MODE_DQUOTE: begin
				emit(c);
				if (lx_escape) begin
					lx_escape = 1'b0;
				end else if (c == jsm_pkg::CH_BSLASH) begin
					lx_escape = 1'b1;
				end else if (c == ((lx_mode == jsm_pkg::MODE_SQUOTE) ?
				                   jsm_pkg::CH_SQUOTE : jsm_pkg::CH_DQUOTE)) begin
					lx_mode = jsm_pkg::MODE_NORMAL;
					lx_prev = c;
				end
			end
			jsm_pkg::MODE_REGEX, jsm_pkg::MODE_RCLASS: begin
				emit(c);
				if (lx_escape) begin
					lx_escape = 1'b0;
				end else if (c == jsm_pkg::CH_BSLASH) begin
					lx_escape = 1'b1;
				end else if (lx_mode == jsm_pkg::MODE_REGEX && c == jsm_pkg::CH_LBRACK) begin
					lx_mode = jsm_pkg::MODE_RCLASS;
				end else if (lx_mode == jsm_pkg::MODE_RCLASS && c == jsm_pkg::CH_RBRACK) begin
					lx_mode = jsm_pkg::MODE_REGEX;
				end else if (lx_mode == jsm_pkg::MODE_REGEX && c == jsm_pkg::CH_SLASH) begin
					lx_mode = jsm_pkg::MODE_FLAGS;
					lx_prev = jsm_pkg::CH_SLASH;
				end
			end
			jsm_pkg::MODE_FLAGS: begin
				if (letter(c)) begin
					emit(c);
				end else begin
					fall = 1'b1;
				end
			end
			default: begin
				fall = 1'b1;
			end
		endcase
		if (fall) begin
			lx_mode = jsm_pkg::MODE_NORMAL;
			if (blank(c)) begin
				lx_gap = 1'b1;
			end else if (c == jsm_pkg::CH_SLASH) begin
				lx_slash = 1'b1;
			end else begin
				plain(c);
			end
		end
	endfunction

	// words that one source byte should yield
	function automatic void minify_step(logic [7:0] c, logic last);
		step_words.delete();
		if (lx_slash && lx_mode == jsm_pkg::MODE_NORMAL) begin
			lx_slash = 1'b0;
			if (c == jsm_pkg::CH_SLASH) begin
				lx_mode = jsm_pkg::MODE_LINE;
			end else if (c == jsm_pkg::CH_STAR) begin
				lx_mode = jsm_pkg::MODE_BLOCK;
				lx_star = 1'b0;
			end else begin
				plain(jsm_pkg::CH_SLASH);
				scan(c);
			end
		end else begin
			lx_slash = 1'b0;
			scan(c);
		end
		// end of text: release a held slash, mark the final word, start afresh
		if (last) begin
			if (lx_slash) begin
				lx_slash = 1'b0;
				plain(jsm_pkg::CH_SLASH);
			end
			if (step_words.size() == 0) begin
				add_step(mini_word_t'{jsm_pkg::CH_NUL, 1'b0, 1'b1});
			end else begin
				step_words[step_words.size() - 1].eot = 1'b1;
			end
			lx_mode = jsm_pkg::MODE_NORMAL;
			lx_escape = 1'b0;
			lx_gap = 1'b0;
			lx_prev = jsm_pkg::CH_NUL;
			lx_tail = jsm_pkg::CH_NUL;
			lx_star = 1'b0;
		end
	endfunction

	function automatic logic [7:0] pick(string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	function automatic logic [7:0] blank_byte();
		int k;
		k = $urandom_range(0, 5);
		return (k == 5) ? jsm_pkg::CH_SPACE : 8'(jsm_pkg::CH_TAB + k);
	endfunction

	// append one random token, mostly well formed, sometimes broken
	function automatic void grow_text();
		logic [7:0] q;
		case ($urandom_range(0, 11))
			// identifier or number
			0: begin
				repeat ($urandom_range(1, 4)) add_char(pick("abzAZmq09_$"));
			end
			1: begin
				repeat ($urandom_range(1, 3)) add_char(blank_byte());
			end
			2: begin
				add_char(pick("([{:;,=!?&|+-*%^~<>)]}."));
			end
			// pairs that must stay apart
			3: begin
				q = pick("+-/");
				add_char(q);
				add_char(blank_byte());
				add_char($urandom_range(0, 1) ? q : jsm_pkg::CH_STAR);
			end
			// division between operands
			4: begin
				add_char(pick("abz09)]"));
				if ($urandom_range(0, 1)) begin
					add_char(jsm_pkg::CH_SPACE);
				end
				add_char(jsm_pkg::CH_SLASH);
				add_char(pick("abz09("));
			end
			// regex literal with classes, escapes and flags
			5: begin
				add_char(pick("=(,:;!&|?{[+"));
				add_char(jsm_pkg::CH_SLASH);
				repeat ($urandom_range(1, 5)) begin
					case ($urandom_range(0, 5))
						0, 1: begin
							add_char(pick("ab.*+?(|)^$ "));
						end
						2, 3: begin
							add_char(jsm_pkg::CH_BSLASH);
							add_char(8'($urandom_range(0, 255)));
						end
						4: begin
							add_char(jsm_pkg::CH_LBRACK);
							add_char(pick("a/\\^-["));
							add_char(jsm_pkg::CH_RBRACK);
						end
						default: begin
							add_char(pick("xy/[]"));
						end
					endcase
				end
				if ($urandom_range(0, 9) != 0) begin
					add_char(jsm_pkg::CH_SLASH);
				end
				repeat ($urandom_range(0, 3)) add_char(pick("gimsuy"));
			end
			// quoted string
			6: begin
				q = $urandom_range(0, 1) ? jsm_pkg::CH_SQUOTE : jsm_pkg::CH_DQUOTE;
				add_char(q);
				repeat ($urandom_range(0, 5)) begin
					case ($urandom_range(0, 3))
						0: begin
							add_char(pick("ab /*x"));
						end
						1: begin
							add_char(jsm_pkg::CH_BSLASH);
							add_char($urandom_range(0, 1) ? q : pick("n\\a"));
						end
						2: begin
							add_char((q == jsm_pkg::CH_SQUOTE) ?
								jsm_pkg::CH_DQUOTE : jsm_pkg::CH_SQUOTE);
						end
						default: begin
							add_char(8'($urandom_range(128, 255)));
						end
					endcase
				end
				if ($urandom_range(0, 9) != 0) begin
					add_char(q);
				end
			end
			// line comment, mostly ended by lf or cr
			7: begin
				add_char(jsm_pkg::CH_SLASH);
				add_char(jsm_pkg::CH_SLASH);
				repeat ($urandom_range(0, 4)) add_char(pick("ab */\"'"));
				if ($urandom_range(0, 6) != 0) begin
					add_char($urandom_range(0, 1) ? jsm_pkg::CH_LF : jsm_pkg::CH_CR);
				end
			end
			// block comment, stars inside
			8: begin
				add_char(jsm_pkg::CH_SLASH);
				add_char(jsm_pkg::CH_STAR);
				repeat ($urandom_range(0, 4)) add_char(pick("ab**/ "));
				if ($urandom_range(0, 6) != 0) begin
					add_char(jsm_pkg::CH_STAR);
					add_char(jsm_pkg::CH_SLASH);
				end
			end
			9: begin
				add_char(8'($urandom_range(0, 255)));
			end
			// held slash released by an ordinary byte
			10: begin
				add_char(jsm_pkg::CH_SLASH);
				add_char(pick("a1( '\"+"));
			end
			default: begin
				add_char(pick("abz09_$"));
				add_char(blank_byte());
				add_char(pick("abz09_$"));
			end
		endcase
	endfunction

	// offer one source word; predict its results once it is taken
	task automatic offer(logic [7:0] b, logic last, logic typed, mini_word_t want);
		while ($urandom_range(0, 99) < idle_pct) begin
			src_valid <= 1'b0;
			@(negedge clk);
		end
		src_valid <= 1'b1;
		src_byte <= b;
		src_last <= last;
		@(posedge clk);
		while (!text_ch.ready) @(posedge clk);
		minify_step(b, last);
		if (typed) begin
			add_due(want);
		end else begin
			foreach (step_words[i]) add_due(step_words[i]);
		end
		@(negedge clk);
	endtask

	// receiver: random stalls, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_off) begin
			sink_ready <= 1'b0;
		end else begin
			sink_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// long hold-off so the bundle queue fills and the input stalls
	initial begin
		@(squeeze_go);
		hold_off <= 1'b1;
		repeat (HoldCycles) @(posedge clk);
		hold_off <= 1'b0;
	end

	// compare each minified word with the oldest prediction
	always @(posedge clk) begin
		mini_word_t want;
		if (arst_n && mini_ch.valid && mini_ch.ready) begin
			if (due_words.size() == 0) begin
				fault_count <= fault_count + 1;
				if (fault_count < ReportLimit) begin
					$display("unexpected word: byte %02h has %0d eot %0d", mini_ch.out_byte,
						mini_ch.has_byte, mini_ch.end_of_text);
				end
			end else begin
				want = due_words.pop_front();
				if (mini_ch.out_byte !== want.b || mini_ch.has_byte !== want.has ||
				    mini_ch.end_of_text !== want.eot) begin
					fault_count <= fault_count + 1;
					if (fault_count < ReportLimit) begin
						$display("mismatch: want %02h/%0d/%0d got %02h/%0d/%0d",
							want.b, want.has, want.eot, mini_ch.out_byte, mini_ch.has_byte,
							mini_ch.end_of_text);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// stimulus
	initial begin
		int sent;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (int i = 0; i < NumRows; i++) begin
			offer(Rows[i].ch, Rows[i].last, Rows[i].typed, Rows[i].want);
		end

		// random texts: full rate, idle sender, stalling receiver, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
					-> squeeze_go;
				end
				1: begin
					idle_pct = 75;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 75;
				end
				default: begin
					idle_pct = 10;
					stall_pct = 10;
				end
			endcase
			sent = 0;
			while (sent < PhaseItems) begin
				text_buf.delete();
				repeat ($urandom_range(1, 10)) grow_text();
				foreach (text_buf[i]) begin
					offer(text_buf[i], i == text_buf.size() - 1, 1'b0, '0);
				end
				sent += text_buf.size();
			end
		end
		src_valid <= 1'b0;

		// drain, then settle
		while (due_words.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (fault_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
